// ----- rtl/kth_smallest_tracker_assert.svh -----
// Assertion macros shared by the kth smallest tracker.
`ifndef KTH_SMALLEST_TRACKER_ASSERT_SVH
`define KTH_SMALLEST_TRACKER_ASSERT_SVH

// Same-cycle implication, checked outside of reset.
`define KST_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("kth smallest tracker: same-cycle check failed");

// Next-cycle implication, checked outside of reset.
`define KST_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kth smallest tracker: next-cycle check failed");

`endif

// ----- rtl/kst_pkg.sv -----
package kst_pkg;

   localparam int VALUE_BITS = 32;
   localparam int RANK_BITS = 5;
   localparam int MAX_RANK_DEFAULT = 16;
   localparam int APB_ADDR_BITS = 3;
   localparam int APB_DATA_BITS = 32;

   // Register word indexes on the configuration port.
   localparam logic REG_RANK_K = 1'b0;

   localparam logic [RANK_BITS-1:0] RANK_K_RESET = RANK_BITS'(1);

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] sample_value;
      logic                         set_end;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] kth_value;
      logic                         answer_valid;
   } rsp_type;

   // What one cell hands to its right-hand neighbor.
   typedef struct packed {
      logic                         greater;
      logic signed [VALUE_BITS-1:0] value;
   } link_type;

   // Broadcast control shared by all cells.
   typedef struct packed {
      logic                         insert;
      logic signed [VALUE_BITS-1:0] key;
   } cell_ctrl_type;

endpackage

// ----- rtl/kst_cell.sv -----
module kst_cell #(
   parameter int INDEX = 0,
   parameter int COUNT_BITS = 5
) (
   input  logic                                  clock,
   input  kst_pkg::cell_ctrl_type                ctrl,
   input  logic [COUNT_BITS-1:0]                 count,
   input  kst_pkg::link_type                     left,
   output kst_pkg::link_type                     right,
   output logic signed [kst_pkg::VALUE_BITS-1:0] value_next
);

   localparam logic [COUNT_BITS-1:0] MY_INDEX = COUNT_BITS'(INDEX);

   logic signed [kst_pkg::VALUE_BITS-1:0] value_ff;
   logic signed [kst_pkg::VALUE_BITS-1:0] value_in;
   logic                                  holds_value;
   logic                                  greater;
   logic                                  take_key;

   // A held entry larger than the key moves one place to the right.
   assign holds_value = MY_INDEX < count;
   assign greater     = holds_value && (value_ff > ctrl.key);
   assign take_key    = (greater || (MY_INDEX == count)) && !left.greater;

   always_comb begin
      value_in = value_ff;
      if (ctrl.insert) begin
         if (left.greater) begin
            value_in = left.value;
         end else if (take_key) begin
            value_in = ctrl.key;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign right.greater = greater;
   assign right.value   = value_ff;
   assign value_next    = value_in;

endmodule

// ----- rtl/kth_smallest_tracker.sv -----
// kth_smallest_tracker: one request per cycle unless stalled, results in the cycle after the set's last request.
// Latency: a result appears at the clock edge that accepts the last request of a set.
// Throughput: one request per clock while no waiting result is stalled; the sorted cell row updates all cells together.
// Reset (synchronous, active high) empties the store and sets the rank register to 1;
// the cell values themselves are not reset and need no clearing pass.
module kth_smallest_tracker #(
   parameter int MAX_RANK = kst_pkg::MAX_RANK_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  kst_pkg::req_type                   req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output kst_pkg::rsp_type                   rsp_payload,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [kst_pkg::APB_ADDR_BITS-1:0]  paddr,
   input  logic [kst_pkg::APB_DATA_BITS-1:0]  pwdata,
   output logic [kst_pkg::APB_DATA_BITS-1:0]  prdata,
   output logic                               pready
);

   `include "kth_smallest_tracker_assert.svh"

   // The count must hold MAX_RANK itself; a cell index needs one value less.
   localparam int COUNT_BITS = $clog2(MAX_RANK + 1);
   localparam int IDX_BITS = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
   localparam logic [COUNT_BITS-1:0] FULL_COUNT = COUNT_BITS'(MAX_RANK);

   // ---------------------------------------------------------------
   // Configuration register. Only the rank register exists; it sits at
   // word index zero, and address bit 2 selects the word.
   // ---------------------------------------------------------------
   logic [kst_pkg::RANK_BITS-1:0] rank_k_ff;
   logic [kst_pkg::RANK_BITS-1:0] rank_k_in;
   logic                          csr_write;
   logic                          csr_hit;

   assign pready    = 1'b1;
   assign csr_hit   = paddr[2] == kst_pkg::REG_RANK_K;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      rank_k_in = rank_k_ff;
      if (csr_write && csr_hit) begin
         rank_k_in = pwdata[kst_pkg::RANK_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_k_ff <= kst_pkg::RANK_K_RESET;
      end else begin
         rank_k_ff <= rank_k_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (csr_hit) begin
         prdata = kst_pkg::APB_DATA_BITS'(rank_k_ff);
      end
   end

   // ---------------------------------------------------------------
   // Effective rank. A rank of zero acts as one, and a rank beyond the
   // depth of the cell row acts as the full depth.
   // ---------------------------------------------------------------
   logic [COUNT_BITS-1:0] rank_eff;
   logic [IDX_BITS-1:0]   last_idx;
   logic [COUNT_BITS-1:0] rank_minus_one;

   always_comb begin
      if (rank_k_ff == '0) begin
         rank_eff = COUNT_BITS'(1);
      end else if (32'(rank_k_ff) > MAX_RANK) begin
         rank_eff = FULL_COUNT;
      end else begin
         rank_eff = COUNT_BITS'(rank_k_ff);
      end
   end

   assign rank_minus_one = rank_eff - COUNT_BITS'(1);
   assign last_idx       = rank_minus_one[IDX_BITS-1:0];

   // ---------------------------------------------------------------
   // Fill count. When the rank was lowered in the middle of a set, the
   // count is clipped first, which drops the largest held values.
   // ---------------------------------------------------------------
   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;
   logic [COUNT_BITS-1:0] count_eff;
   logic                  not_full;

   assign count_eff = (count_ff > rank_eff) ? rank_eff : count_ff;
   assign not_full  = count_eff < rank_eff;

   // ---------------------------------------------------------------
   // Cell row. Cells hold the kept values in ascending order. Every cell
   // compares its value with the new key at once; the cell at the insert
   // point takes the key and each larger cell takes its left neighbor.
   // When the row is full, the key goes in only if it is strictly smaller
   // than the largest kept value, which then falls off the end.
   // ---------------------------------------------------------------
   kst_pkg::link_type                     links [MAX_RANK+1];
   logic signed [kst_pkg::VALUE_BITS-1:0] next_values [MAX_RANK];
   logic [MAX_RANK-1:0]                   greater_vec;
   kst_pkg::cell_ctrl_type                cell_ctrl;
   logic                                  accept;
   logic                                  do_insert;

   assign accept    = req_valid && !req_stall;
   assign do_insert = not_full || greater_vec[last_idx];

   assign cell_ctrl.insert = accept && do_insert;
   assign cell_ctrl.key    = req_payload.sample_value;

   assign links[0].greater = 1'b0;
   assign links[0].value   = '0;

   for (genvar i = 0; i < MAX_RANK; i++) begin : g_cell
      kst_cell #(
         .INDEX      (i),
         .COUNT_BITS (COUNT_BITS)
      ) u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .count      (count_eff),
         .left       (links[i]),
         .right      (links[i+1]),
         .value_next (next_values[i])
      );
      assign greater_vec[i] = links[i+1].greater;
   end

   // The end of a set empties the store; otherwise a non-full row grows.
   always_comb begin
      count_in = count_ff;
      if (accept) begin
         if (req_payload.set_end) begin
            count_in = '0;
         end else if (not_full) begin
            count_in = count_eff + COUNT_BITS'(1);
         end else begin
            count_in = count_eff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // ---------------------------------------------------------------
   // Result register. The answer is valid when the row holds rank values
   // after taking in the last request, that is when it was full already
   // or one short of full. The value is the new content of the cell at
   // rank minus one. Requests stall only while a result waits and the
   // consumer stalls it.
   // ---------------------------------------------------------------
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   kst_pkg::rsp_type rsp_ff;
   kst_pkg::rsp_type rsp_in;
   logic             answer_ok;

   assign answer_ok = !not_full || (count_eff == rank_minus_one);
   assign req_stall = rsp_valid_ff && rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (accept && req_payload.set_end) begin
         rsp_valid_in        = 1'b1;
         rsp_in.answer_valid = answer_ok;
         rsp_in.kth_value    = answer_ok ? next_values[last_idx] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // ---------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------
   `KST_ASSERT_NOW(a_count_in_range, clock, reset, 1'b1, count_ff <= FULL_COUNT)
   `KST_ASSERT_NEXT(a_end_gives_result, clock, reset, accept && req_payload.set_end,
                    rsp_valid_ff && (count_ff == '0))
   `KST_ASSERT_NOW(a_short_set_zero, clock, reset, rsp_valid_ff && !rsp_ff.answer_valid,
                   rsp_ff.kth_value == '0)
   `KST_ASSERT_NEXT(a_grow_by_one, clock, reset,
                    accept && !req_payload.set_end && not_full,
                    count_ff == $past(count_eff) + COUNT_BITS'(1))

endmodule

// ----- sim/kst_scoreboard_pkg.sv -----
`timescale 1ns / 100ps

package kst_scoreboard_pkg;

   import kst_pkg::*;

   class kth_scoreboard;

      logic [RANK_BITS-1:0]         rank_reg;
      logic signed [VALUE_BITS-1:0] held_values[$];
      rsp_type                      awaited_answers[$];
      int                           errors;
      int                           requests_seen;
      int                           answers_seen;
      int                           full_answers;
      int                           short_answers;

      function new();
         rank_reg      = RANK_K_RESET;
         errors        = 0;
         requests_seen = 0;
         answers_seen  = 0;
         full_answers  = 0;
         short_answers = 0;
      endfunction

      function void set_rank(logic [RANK_BITS-1:0] r);
         rank_reg = r;
      endfunction

      // A rank of zero acts as one; anything past the store depth acts as the depth.
      function int rank_in_use();
         if (rank_reg == 0) return 1;
         if (rank_reg > MAX_RANK_DEFAULT) return MAX_RANK_DEFAULT;
         return int'(rank_reg);
      endfunction

      // Keeps the held list ascending; equal values go behind the ones already held.
      function void place_value(logic signed [VALUE_BITS-1:0] v);
         int pos = 0;
         while (pos < held_values.size() && held_values[pos] <= v) pos++;
         held_values.insert(pos, v);
      endfunction

      function void note_request(req_type r);
         int                           k = rank_in_use();
         logic signed [VALUE_BITS-1:0] v = r.sample_value;
         rsp_type                      answer;
         requests_seen++;
         // The rank may have dropped since the last request of this set.
         while (held_values.size() > k) void'(held_values.pop_back());
         if (held_values.size() < k) begin
            place_value(v);
         end else if (v < held_values[k-1]) begin
            void'(held_values.pop_back());
            place_value(v);
         end
         if (r.set_end) begin
            answer = '0;
            if (held_values.size() >= k) begin
               answer.kth_value    = held_values[k-1];
               answer.answer_valid = 1'b1;
            end
            awaited_answers.push_back(answer);
            held_values.delete();
         end
      endfunction

      task report_mismatch(string what);
         $display("MISMATCH at %0t: %s", $time, what);
         errors++;
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         if (awaited_answers.size() == 0) begin
            report_mismatch($sformatf("answer %0d valid %0b with none awaited",
                                      got.kth_value, got.answer_valid));
            return;
         end
         want = awaited_answers.pop_front();
         answers_seen++;
         if (want.answer_valid) full_answers++;
         else short_answers++;
         if (got.answer_valid !== want.answer_valid)
            report_mismatch($sformatf("answer_valid %0b, wanted %0b",
                                      got.answer_valid, want.answer_valid));
         if (got.kth_value !== want.kth_value)
            report_mismatch($sformatf("kth_value %0d, wanted %0d",
                                      got.kth_value, want.kth_value));
      endtask

   endclass

endpackage

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

   import kst_pkg::*;
   import kst_scoreboard_pkg::*;

   // The output side stalls this long once, so that the block backs up its input.
   localparam int LONG_HOLD = 80;
   // Cycles of margin after the last answer before the rank register is touched.
   localparam int SETTLE_CYCLES = 4;
   localparam int RANDOM_REQUESTS = 1450;

   localparam logic [APB_ADDR_BITS-1:0] RANK_K_ADDR = APB_ADDR_BITS'({REG_RANK_K, 2'b00});
   localparam logic signed [VALUE_BITS-1:0] VAL_MAX = 32'sh7fff_ffff;
   localparam logic signed [VALUE_BITS-1:0] VAL_MIN = 32'sh8000_0000;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   req_type                  req_payload;
   logic                     rsp_valid;
   logic                     rsp_stall;
   rsp_type                  rsp_payload;
   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [APB_ADDR_BITS-1:0] paddr;
   logic [APB_DATA_BITS-1:0] pwdata;
   logic [APB_DATA_BITS-1:0] prdata;
   logic                     pready;

   kth_scoreboard sb = new();

   // The first two are shared between the request driver and the output-side stall process.
   bit no_idle;
   bit hold_request;
   int requests_sent;
   int rank_settings;

   kth_smallest_tracker #(
      .MAX_RANK(MAX_RANK_DEFAULT)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // A hard stop well beyond the slowest legal run.
   initial begin
      #5000000;
      $display("Verification failed");
      $finish;
   end

   // Gap lengths are mostly zero or short, with the occasional long one.
   function automatic int pick_gap();
      int sel = $urandom_range(0, 99);
      if (sel < 60) return 0;
      if (sel < 90) return $urandom_range(1, 3);
      if (sel < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 50);
   endfunction

   // Values are a mix of the full range, a narrow band that yields many duplicates,
   // and the extremes of the signed range.
   function automatic logic signed [VALUE_BITS-1:0] pick_value();
      int sel = $urandom_range(0, 9);
      if (sel < 5) return $urandom;
      if (sel < 8) return $urandom_range(0, 16) - 8;
      case ($urandom_range(0, 3))
         0: return VAL_MIN;
         1: return VAL_MAX;
         2: return VAL_MIN + 1;
         default: return VAL_MAX - 1;
      endcase
   endfunction

   // Both sides are sampled here at the clock edge. An answer is checked before the
   // request of the same edge is noted, since that request's answer can only show
   // up after this edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_payload);
         if (req_valid && !req_stall) sb.note_request(req_payload);
      end
   end

   // Output-side stall pattern. A request for a long hold-off holds the stall high
   // while this process counts out the hold-off on its own.
   initial begin
      int   run;
      int   held_cycles;
      logic level;
      rsp_stall <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            held_cycles = 0;
            while (held_cycles < LONG_HOLD) begin
               @(posedge clock);
               held_cycles++;
            end
         end else begin
            level = !no_idle && ($urandom_range(0, 2) == 0);
            run = no_idle ? 1 : pick_gap() + 1;
            rsp_stall <= level;
            repeat (run) @(posedge clock);
         end
      end
   end

   // Offers one request after a random gap and returns at the edge that takes it.
   // When there is no gap, valid simply stays high for the next request.
   task automatic send_request(logic signed [VALUE_BITS-1:0] v, logic last);
      int gap = no_idle ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_payload <= '{sample_value: v, set_end: last};
      req_valid   <= 1'b1;
      do @(posedge clock); while (req_stall);
      requests_sent++;
   endtask

   // Sends n random values; only a closed set gets the end flag on its last one.
   task automatic send_set(int n, bit close);
      for (int i = 0; i < n; i++) send_request(pick_value(), close && (i == n - 1));
   endtask

   // Stops offering requests and waits until every awaited answer has come back,
   // then waits out the settle margin for a request that makes no answer. The first
   // check comes only once the last request has been noted.
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.awaited_answers.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes the rank register and reads it straight back in a second transfer.
   // The write lands at the access-phase edge, so the predictor takes the new rank
   // at once; nothing is in flight while this runs.
   task automatic csr_set_rank(logic [RANK_BITS-1:0] r);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= RANK_K_ADDR;
      pwdata  <= APB_DATA_BITS'(r);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.set_rank(r);
      rank_settings++;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== APB_DATA_BITS'(r))
         sb.report_mismatch($sformatf("rank_k reads %0d, wrote %0d", prdata, r));
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   initial begin
      int                   phase;
      int                   k_eff;
      int                   set_len;
      int                   n_sets;
      bit                   leave_open;
      logic [RANK_BITS-1:0] r;

      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_payload   <= '0;
      psel          <= 1'b0;
      penable       <= 1'b0;
      pwrite        <= 1'b0;
      paddr         <= '0;
      pwdata        <= '0;
      no_idle       = 1'b0;
      hold_request  = 1'b0;
      requests_sent = 0;
      rank_settings = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part. The first set runs on the rank left by reset, which is one.
      send_request(5, 1'b1);
      wait_idle();

      // Rank three over both signed extremes, zero and minus one.
      csr_set_rank(RANK_BITS'(3));
      send_request(VAL_MAX, 1'b0);
      send_request(VAL_MIN, 1'b0);
      send_request(0, 1'b0);
      send_request(-1, 1'b0);
      send_request(7, 1'b1);
      // A set shorter than the rank gives an answer that is not valid.
      send_request(10, 1'b0);
      send_request(20, 1'b1);
      wait_idle();

      // Equal values are held up to the rank, and an equal value never displaces the largest.
      csr_set_rank(RANK_BITS'(2));
      send_request(4, 1'b0);
      send_request(4, 1'b0);
      send_request(4, 1'b1);
      wait_idle();

      // A rank of zero behaves as rank one.
      csr_set_rank(RANK_BITS'(0));
      send_request(9, 1'b0);
      send_request(-3, 1'b1);
      wait_idle();

      // A rank above the store depth behaves as the depth, so one value is too few.
      csr_set_rank(RANK_BITS'(31));
      send_request(1, 1'b1);
      wait_idle();

      // The rank drops in the middle of a set: the largest held values go first.
      csr_set_rank(RANK_BITS'(4));
      send_request(8, 1'b0);
      send_request(6, 1'b0);
      send_request(7, 1'b0);
      send_request(5, 1'b0);
      wait_idle();
      csr_set_rank(RANK_BITS'(2));
      send_request(9, 1'b1);
      wait_idle();

      csr_set_rank(RANK_BITS'(1));
      send_request(VAL_MIN, 1'b1);
      send_request(VAL_MAX, 1'b1);

      // Random part. Each phase picks a rank, with the extremes coming round
      // regularly, then sends a run of sets sized mostly around that rank. Now and
      // then a phase leaves its last set open, so the next rank change lands in
      // the middle of a set.
      phase = 0;
      while (requests_sent < RANDOM_REQUESTS + 21) begin
         wait_idle();
         case (phase % 6)
            0: r = RANK_BITS'(1);
            1: r = RANK_BITS'(16);
            2: r = RANK_BITS'($urandom_range(17, 31));
            3: r = RANK_BITS'(0);
            default: r = RANK_BITS'($urandom_range(1, 16));
         endcase
         no_idle = (phase % 7 == 3);
         n_sets  = $urandom_range(3, 8);
         // One phase of tiny sets at full rate while the output side holds off for
         // a long stretch, so answers pile up and the input stalls.
         if (phase == 4) begin
            r            = RANK_BITS'(1);
            no_idle      = 1'b1;
            n_sets       = 30;
            hold_request = 1'b1;
         end
         csr_set_rank(r);
         // The sets of the hold-off phase start only once the hold-off has begun.
         if (phase == 4) begin
            while (hold_request) @(posedge clock);
         end
         k_eff = (r == 0) ? 1 : (r > MAX_RANK_DEFAULT) ? MAX_RANK_DEFAULT : int'(r);
         leave_open = ($urandom_range(0, 5) == 0);
         repeat (n_sets) begin
            case ($urandom_range(0, 9))
               0, 1: set_len = $urandom_range(1, k_eff);
               2: set_len = $urandom_range(k_eff + 7, k_eff + 30);
               default: set_len = $urandom_range(k_eff, k_eff + 6);
            endcase
            if (phase == 4) set_len = $urandom_range(1, 2);
            send_set(set_len, 1'b1);
         end
         if (leave_open) send_set($urandom_range(1, k_eff + 2), 1'b0);
         phase++;
      end

      // Close whatever set is still open, then drain.
      no_idle = 1'b0;
      send_request(pick_value(), 1'b1);
      wait_idle();

      $display("Run covered %0d requests over %0d rank settings,",
               sb.requests_seen, rank_settings);
      $display("including a %0d-cycle output hold-off.", LONG_HOLD);
      $display("Checked %0d answers: %0d from full sets and %0d from short sets.",
               sb.answers_seen, sb.full_answers, sb.short_answers);
      if (sb.errors == 0 && sb.awaited_answers.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
